// ----- hw/rtl/pmfb_pkg.sv -----
// ----------------------------------------------------------------------------
// pmfb_pkg
// shared types, codes and constants of the page mode framebuffer refresh block
// ----------------------------------------------------------------------------
package pmfb_pkg;

  localparam int PANEL_WIDTH_DEF  = 128;
  localparam int PANEL_HEIGHT_DEF = 64;
  localparam int PAGE_ROWS        = 8;
  localparam int HEADER_STEPS     = 3;

  localparam logic [1:0] KIND_DRAW  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic       pixel_on;
  } item_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       is_data;
    logic       last_of_refresh;
  } result_t;

  typedef struct packed {
    logic load;
    logic clear_we;
    logic draw_we;
    logic arm;
    logic emit_cmd;
    logic emit_data;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       draw_ok;
    logic       active;
    logic       cmd_step;
    logic       clear_last;
  } dp_status_t;

endpackage

// ----- hw/rtl/page_mode_framebuffer_refresh_top.sv -----
// ----------------------------------------------------------------------------
// page_mode_framebuffer_refresh_top
// monochrome page mode framebuffer with a panel refresh byte stream
// ----------------------------------------------------------------------------
// an item transfer happens at a clock edge with start high and busy low.
// item.kind selects: draw a pixel, start a refresh, or tick one refresh byte.
// each page of a refresh sends three command bytes, then its column bytes.
// a result is on result for one cycle with strobe high; it cannot be stalled.
// the steps of an item follow from the frame store's one write port and its registered read:
//   draw in range: read, modify, write; off panel: no write
//   start: arms the refresh; tick: emits a command byte, or reads then emits a data byte
// a command strobe follows the exec state, a data strobe the emit state after it;
// busy drops in the same cycle as that strobe, so the next item overlaps it.
// after reset the store's PANEL_WIDTH * ceil(PANEL_HEIGHT / 8) entries
// (1024 at the defaults) are cleared one entry a cycle;
// busy is held high until that sweep is done.
// ----------------------------------------------------------------------------
module page_mode_framebuffer_refresh_top #(
  parameter int PANEL_WIDTH  = pmfb_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = pmfb_pkg::PANEL_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pmfb_pkg::item_t   item,
  output pmfb_pkg::result_t result,
  output logic              strobe
);

  pmfb_pkg::ctrl_cmd_t  cmd;
  pmfb_pkg::dp_status_t stat;

  pmfb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  pmfb_datapath #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .stat   (stat),
    .item   (item),
    .result (result),
    .strobe (strobe)
  );

endmodule

// ----- hw/rtl/pmfb_ctrl.sv -----
// ----------------------------------------------------------------------------
// pmfb_ctrl
// sequencer for store clearing, pixel read-modify-write and refresh bytes
// ----------------------------------------------------------------------------
module pmfb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  pmfb_pkg::dp_status_t stat,
  output pmfb_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_WRITE,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_we = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        case (stat.kind)
          pmfb_pkg::KIND_DRAW: begin
            if (stat.draw_ok) begin
              state_next = S_WRITE;
            end
          end
          pmfb_pkg::KIND_START: begin
            cmd.arm = 1'b1;
          end
          pmfb_pkg::KIND_TICK: begin
            if (stat.active) begin
              if (stat.cmd_step) begin
                cmd.emit_cmd = 1'b1;
              end else begin
                state_next = S_EMIT;
              end
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_WRITE: begin
        cmd.draw_we = 1'b1;
        state_next  = S_IDLE;
      end
      S_EMIT: begin
        cmd.emit_data = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      busy  <= 1'b1;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

// ----- hw/rtl/pmfb_datapath.sv -----
// ----------------------------------------------------------------------------
// pmfb_datapath
// frame store, refresh counters and result register
// ----------------------------------------------------------------------------
module pmfb_datapath #(
  parameter int PANEL_WIDTH  = pmfb_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = pmfb_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pmfb_pkg::ctrl_cmd_t  cmd,
  output pmfb_pkg::dp_status_t stat,
  input  pmfb_pkg::item_t      item,
  output pmfb_pkg::result_t    result,
  output logic                 strobe
);

  localparam int PAGE_COUNT = PANEL_HEIGHT / pmfb_pkg::PAGE_ROWS;
  localparam int PAGE_SLOTS = (PANEL_HEIGHT + pmfb_pkg::PAGE_ROWS - 1) / pmfb_pkg::PAGE_ROWS;
  localparam int DEPTH      = PANEL_WIDTH * PAGE_SLOTS;
  localparam int AW         = $clog2(DEPTH);
  localparam logic [7:0]    LAST_STEP  = 8'(PANEL_WIDTH + pmfb_pkg::HEADER_STEPS - 1);
  localparam logic [2:0]    LAST_PAGE  = 3'(PAGE_COUNT - 1);
  localparam logic [AW-1:0] LAST_ENTRY = AW'(DEPTH - 1);

  pmfb_pkg::item_t cur;
  logic            active;
  logic [2:0]      page;
  logic [7:0]      step;
  logic [AW-1:0]   clr_addr;
  logic [7:0]      mem [DEPTH];
  logic [7:0]      rdata;

  logic [15:0]   draw_sum;
  logic [15:0]   tick_sum;
  logic [7:0]    col;
  logic [AW-1:0] draw_addr;
  logic [AW-1:0] raddr;
  logic [7:0]    bit_mask;
  logic [7:0]    wdata;
  logic [7:0]    cmd_byte;
  logic          last;

  always_comb begin
    col       = step - 8'(pmfb_pkg::HEADER_STEPS);
    draw_sum  = 16'(cur.pixel_x) + 16'(cur.pixel_y[7:3]) * 16'(PANEL_WIDTH);
    tick_sum  = 16'(col) + 16'(page) * 16'(PANEL_WIDTH);
    draw_addr = draw_sum[AW-1:0];
    raddr     = (cur.kind == pmfb_pkg::KIND_DRAW) ? draw_addr : tick_sum[AW-1:0];
    bit_mask  = 8'd1 << cur.pixel_y[2:0];
    wdata     = cur.pixel_on ? (rdata | bit_mask) : (rdata & ~bit_mask);
    last      = (step == LAST_STEP) && (page == LAST_PAGE);
    case (step)
      8'd0:    cmd_byte = pmfb_pkg::CMD_PAGE_BASE + 8'(page);
      8'd1:    cmd_byte = pmfb_pkg::CMD_COL_LOW;
      default: cmd_byte = pmfb_pkg::CMD_COL_HIGH;
    endcase
  end

  assign stat.kind       = cur.kind;
  assign stat.draw_ok    = (9'(cur.pixel_x) < 9'(PANEL_WIDTH)) &&
                           (9'(cur.pixel_y) < 9'(PANEL_HEIGHT));
  assign stat.active     = active;
  assign stat.cmd_step   = (step < 8'(pmfb_pkg::HEADER_STEPS));
  assign stat.clear_last = (clr_addr == LAST_ENTRY);

  // frame store
  always_ff @(posedge clk) begin
    if (cmd.clear_we) begin
      mem[clr_addr] <= '0;
    end else if (cmd.draw_we) begin
      mem[draw_addr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= item;
    end
    if (cmd.emit_cmd) begin
      result <= '{byte_value: cmd_byte, is_data: 1'b0, last_of_refresh: 1'b0};
    end else if (cmd.emit_data) begin
      result <= '{byte_value: rdata, is_data: 1'b1, last_of_refresh: last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      page     <= '0;
      step     <= '0;
      clr_addr <= '0;
      strobe   <= 1'b0;
    end else begin
      strobe <= cmd.emit_cmd | cmd.emit_data;
      if (cmd.clear_we) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.arm) begin
        active <= 1'b1;
        page   <= '0;
        step   <= '0;
      end else if (cmd.emit_cmd || cmd.emit_data) begin
        if (step == LAST_STEP) begin
          step <= '0;
          if (page == LAST_PAGE) begin
            page   <= '0;
            active <= 1'b0;
          end else begin
            page <= page + 3'd1;
          end
        end else begin
          step <= step + 8'd1;
        end
      end
    end
  end

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// checks the page mode framebuffer refresh block against a cycle-free
// behavioral image of its frame store and refresh sequencer: pixel draws,
// refresh starts and restarts, command and data bytes, the final-byte flag
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIDTH        = pmfb_pkg::PANEL_WIDTH_DEF;
  localparam int HEIGHT       = pmfb_pkg::PANEL_HEIGHT_DEF;
  localparam int PAGES        = HEIGHT / pmfb_pkg::PAGE_ROWS;
  localparam int STORE_DEPTH  = 1024;
  localparam int PAGE_STEPS   = WIDTH + pmfb_pkg::HEADER_STEPS;
  localparam int ITEM_TARGET  = 250;
  localparam int SETTLE_WAIT  = 6;
  localparam int QUIET_LIMIT  = 4000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    pmfb_pkg::item_t it;
    bit              hold;
    int unsigned     gap_pct;
  } pending_t;

  logic              clk   = 1'b0;
  logic              rst   = 1'b1;
  logic              start = 1'b0;
  pmfb_pkg::item_t   item  = '0;
  logic              busy;
  pmfb_pkg::result_t result;
  logic              strobe;

  pending_t          pending_items[$];
  pmfb_pkg::result_t expected_stream[$];
  logic              took = 1'b0;
  int                settle = 0;
  int                quiet_cycles = 0;
  int                errors = 0;

  bit [7:0] shadow_fb [STORE_DEPTH];
  bit       shadow_active = 1'b0;
  int       shadow_page = 0;
  int       shadow_step = 0;

  page_mode_framebuffer_refresh_top #(
    .PANEL_WIDTH (WIDTH),
    .PANEL_HEIGHT(HEIGHT)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .item  (item),
    .result(result),
    .strobe(strobe)
  );

  initial forever #2 clk = ~clk;

  task automatic predict_panel_stream(input pmfb_pkg::item_t it);
    int                col;
    int                addr;
    pmfb_pkg::result_t r;
    r = '0;
    case (it.kind)
      pmfb_pkg::KIND_DRAW: begin
        if (it.pixel_x < WIDTH && it.pixel_y < HEIGHT) begin
          addr = (int'(it.pixel_x) + (int'(it.pixel_y) / pmfb_pkg::PAGE_ROWS) * WIDTH)
                 % STORE_DEPTH;
          shadow_fb[addr][it.pixel_y[2:0]] = it.pixel_on;
        end
      end
      pmfb_pkg::KIND_START: begin
        shadow_active = 1'b1;
        shadow_page = 0;
        shadow_step = 0;
      end
      pmfb_pkg::KIND_TICK: begin
        if (shadow_active) begin
          if (shadow_step == 0) begin
            r.byte_value = pmfb_pkg::CMD_PAGE_BASE + 8'(shadow_page);
          end else if (shadow_step == 1) begin
            r.byte_value = pmfb_pkg::CMD_COL_LOW;
          end else if (shadow_step == 2) begin
            r.byte_value = pmfb_pkg::CMD_COL_HIGH;
          end else begin
            col = shadow_step - pmfb_pkg::HEADER_STEPS;
            r.byte_value = shadow_fb[(col + shadow_page * WIDTH) % STORE_DEPTH];
            r.is_data = 1'b1;
            r.last_of_refresh = (shadow_page + 1 == PAGES) && (col + 1 == WIDTH);
          end
          expected_stream.push_back(r);
          shadow_step++;
          if (shadow_step >= PAGE_STEPS) begin
            shadow_step = 0;
            shadow_page++;
            if (shadow_page >= PAGES) begin
              shadow_page = 0;
              shadow_active = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic pmfb_pkg::item_t make_item(logic [1:0] kind, int x, int y, bit on);
    pmfb_pkg::item_t it;
    it.kind = kind;
    it.pixel_x = 8'(x);
    it.pixel_y = 8'(y);
    it.pixel_on = on;
    return it;
  endfunction

  function automatic pmfb_pkg::item_t random_draw(bit on_panel);
    if (on_panel)
      return make_item(pmfb_pkg::KIND_DRAW, $urandom_range(WIDTH - 1),
                       $urandom_range(HEIGHT - 1), 1'($urandom_range(1)));
    return make_item(pmfb_pkg::KIND_DRAW, $urandom_range(255), $urandom_range(255),
                     1'($urandom_range(1)));
  endfunction

  function automatic pmfb_pkg::item_t random_tick();
    return make_item(pmfb_pkg::KIND_TICK, $urandom_range(255), $urandom_range(255),
                     1'($urandom_range(1)));
  endfunction

  task automatic queue_item(input pmfb_pkg::item_t it);
    pending_items.push_back('{it: it, hold: 1'b0, gap_pct: 0});
  endtask

  // item driver: one transfer per start/busy handshake, random sender gaps
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      item <= '0;
      settle <= 0;
    end else if (!start || took) begin
      if (pending_items.size() == 0) begin
        start <= 1'b0;
      end else if (pending_items[0].hold) begin
        start <= 1'b0;
        if (expected_stream.size() != 0) begin
          settle <= 0;
        end else if (settle < SETTLE_WAIT) begin
          settle <= settle + 1;
        end else begin
          void'(pending_items.pop_front());
          settle <= 0;
        end
      end else if ($urandom_range(99) < pending_items[0].gap_pct) begin
        start <= 1'b0;
      end else begin
        item <= pending_items[0].it;
        start <= 1'b1;
        void'(pending_items.pop_front());
      end
    end
  end

  // result monitor and item tracking
  always @(posedge clk) begin
    pmfb_pkg::result_t want;
    if (!rst) begin
      if (strobe) begin
        if (expected_stream.size() == 0) begin
          $error("unexpected result byte_value %02h is_data %0b last_of_refresh %0b",
                 result.byte_value, result.is_data, result.last_of_refresh);
          errors++;
        end else begin
          want = expected_stream.pop_front();
          if (result.byte_value !== want.byte_value) begin
            $error("byte_value expected %02h actual %02h", want.byte_value, result.byte_value);
            errors++;
          end
          if (result.is_data !== want.is_data) begin
            $error("is_data expected %0b actual %0b", want.is_data, result.is_data);
            errors++;
          end
          if (result.last_of_refresh !== want.last_of_refresh) begin
            $error("last_of_refresh expected %0b actual %0b",
                   want.last_of_refresh, result.last_of_refresh);
            errors++;
          end
        end
      end
      if (start && !busy) predict_panel_stream(item);
    end
    took <= !rst && start && !busy;
  end

  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int              n_rand;
    int              ticks;
    int              count;
    int              total;
    pmfb_pkg::item_t it;

    // directed: idle tick, unused kind, field extremes, off-panel draws, pixel set and clear, a start with ticks
    queue_item(make_item(pmfb_pkg::KIND_TICK, 0, 0, 1'b0));
    queue_item(make_item(KIND_UNUSED, 255, 255, 1'b1));
    queue_item(make_item(pmfb_pkg::KIND_DRAW, 0, 0, 1'b1));
    queue_item(make_item(pmfb_pkg::KIND_DRAW, WIDTH - 1, HEIGHT - 1, 1'b1));
    queue_item(make_item(pmfb_pkg::KIND_DRAW, WIDTH, 0, 1'b1));
    queue_item(make_item(pmfb_pkg::KIND_DRAW, 0, HEIGHT, 1'b1));
    queue_item(make_item(pmfb_pkg::KIND_DRAW, 255, 255, 1'b1));
    queue_item(make_item(pmfb_pkg::KIND_DRAW, WIDTH - 1, 0, 1'b1));
    queue_item(make_item(pmfb_pkg::KIND_DRAW, 0, HEIGHT - 1, 1'b1));
    queue_item(make_item(pmfb_pkg::KIND_DRAW, 3, 10, 1'b1));
    queue_item(make_item(pmfb_pkg::KIND_DRAW, 3, 10, 1'b0));
    queue_item(make_item(pmfb_pkg::KIND_DRAW, 3, 11, 1'b1));
    queue_item(make_item(pmfb_pkg::KIND_START, 0, 0, 1'b0));
    repeat (4) queue_item(make_item(pmfb_pkg::KIND_TICK, 0, 0, 1'b0));
    // draw during refresh, seen by the next data byte
    queue_item(make_item(pmfb_pkg::KIND_DRAW, 1, 0, 1'b1));
    queue_item(make_item(pmfb_pkg::KIND_TICK, 0, 0, 1'b0));
    // restart mid refresh
    queue_item(make_item(pmfb_pkg::KIND_START, 0, 0, 1'b0));
    repeat (3) queue_item(make_item(pmfb_pkg::KIND_TICK, 255, 255, 1'b1));
    pending_items.push_back('{it: '0, hold: 1'b1, gap_pct: 0});

    // one full refresh with draws mixed in, then a full drain
    queue_item(make_item(pmfb_pkg::KIND_START, $urandom_range(255), $urandom_range(255),
                         1'b1));
    ticks = 0;
    while (ticks < PAGES * PAGE_STEPS) begin
      if ($urandom_range(99) < 5) begin
        queue_item(random_draw($urandom_range(9) != 0));
      end else begin
        queue_item(random_tick());
        ticks++;
      end
    end
    pending_items.push_back('{it: '0, hold: 1'b1, gap_pct: 0});

    n_rand = 0;
    while (n_rand < ITEM_TARGET) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          queue_item(make_item(pmfb_pkg::KIND_START, $urandom_range(255),
                               $urandom_range(255), 1'($urandom_range(1))));
          count = $urandom_range(150, 10);
          for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 20) queue_item(random_draw($urandom_range(7) != 0));
            else queue_item(random_tick());
          end
          n_rand += count + 1;
        end
        6, 7: begin
          count = $urandom_range(30, 5);
          for (int i = 0; i < count; i++) queue_item(random_draw($urandom_range(5) != 0));
          n_rand += count;
        end
        default: begin
          count = $urandom_range(20, 5);
          for (int i = 0; i < count; i++) begin
            it = make_item(2'($urandom_range(3)), $urandom_range(255), $urandom_range(255),
                           1'($urandom_range(1)));
            queue_item(it);
          end
          n_rand += count;
        end
      endcase
    end

    total = pending_items.size();
    foreach (pending_items[i]) begin
      if (i < total / 3) pending_items[i].gap_pct = 30;
      else if (i < 2 * total / 3) pending_items[i].gap_pct = 52;
      else pending_items[i].gap_pct = 0;
    end

    repeat (3) @(negedge clk);
    rst = 1'b0;

    while (pending_items.size() != 0 || start || expected_stream.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_stream.size() != 0) begin
      $error("%0d expected results never arrived", expected_stream.size());
      errors++;
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/pmfb_pkg.sv
hw/rtl/pmfb_ctrl.sv
hw/rtl/pmfb_datapath.sv
hw/rtl/page_mode_framebuffer_refresh_top.sv
bench/tb.sv
